### design/gjd_pkg.sv
// ----------------------------------------------------------------------------
// gjd_pkg: shared types and constants of the day number converter
// word layouts, calendar table and fixed-point reciprocals
// ----------------------------------------------------------------------------
`default_nettype none

package gjd_pkg;

  localparam int unsigned NumStages = 7;

  // operation codes
  localparam logic OpToJdn  = 1'b0;
  localparam logic OpToDate = 1'b1;

  localparam logic [22:0] JdnOffset = 23'd1721425;
  localparam logic [22:0] JdnMax    = 23'd5373484;

  // year estimate: t * (2^32 / 365.2425), integer part
  localparam int unsigned TW        = 22;
  localparam int unsigned EstRecipW = 24;
  localparam int unsigned EstProdW  = TW + EstRecipW;
  localparam int unsigned EstShift  = 32;
  localparam logic [EstRecipW-1:0] EstRecip = 24'd11759221;

  // divide by 100 for values below 2^14: (p * 20972) >> 21 is exact
  localparam int unsigned Recip100W     = 15;
  localparam int unsigned Div100ProdW   = 14 + Recip100W;
  localparam int unsigned Div100Shift   = 21;
  localparam logic [Recip100W-1:0] Recip100 = 15'd20972;

  typedef struct packed {
    logic        op;
    logic [13:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [22:0] day_number_in;
  } gjd_req_t;

  typedef struct packed {
    logic        valid_res;
    logic [22:0] day_number_out;
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
  } gjd_rsp_t;

  // per-word side data carried along the front of the pipe
  typedef struct packed {
    logic          op;
    logic          ok;
    logic          feb29;
    logic          mgt2;
    logic [8:0]    doy0;
    logic [TW-1:0] t;
  } side_t;

  // year unit result
  typedef struct packed {
    logic [13:0]        yw;
    logic signed [23:0] dby;
    logic               leap_m1;
    logic               leap0;
    logic               leap_p1;
  } yinfo_t;

  // corrected year and day of year
  typedef struct packed {
    logic        op;
    logic        ok;
    logic [22:0] jdn;
    logic [13:0] yr;
    logic [8:0]  n;
    logic        lf;
  } fix_t;

  // days in the first m months of a common year (m = 0..12)
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      4'd12:   r = 9'd365;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### design/gjd_if.sv
// ----------------------------------------------------------------------------
// gjd_if: request and response channels
// valid/ready handshake with the word as payload
// ----------------------------------------------------------------------------
`default_nettype none

interface gjd_req_if;
  logic               valid;
  logic               ready;
  gjd_pkg::gjd_req_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gjd_rsp_if;
  logic               valid;
  logic               ready;
  gjd_pkg::gjd_rsp_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/gregorian_julian_day_converter.sv
// ----------------------------------------------------------------------------
// gregorian_julian_day_converter: Gregorian date <-> Julian day number
// seven-stage pipeline, if the response side does not stall, one word per clock
// ----------------------------------------------------------------------------
// Each request word converts a date (op 0) to a Julian day number or a day
// number in 1721425..5373484 (op 1) back to year, month and day; illegal
// inputs return valid_res low with all other fields zero. The pipe has seven
// register stages (input checks, year estimate multiply, divide-by-100
// multiply, days-before-year sum, day number sum, year correction, month
// split into the output register), and a new word is taken every cycle while
// the pipe is not stalled by the response side. Every stage has its own valid
// bit and loads whenever it is empty or the stage after it moves, so a stall
// on the response side only backs up as far as the pipe is full and bubbles
// are squeezed out.
`default_nettype none

module gregorian_julian_day_converter (
  input  logic       clk_i,
  input  logic       rst_ni,
  gjd_req_if.sink    req_i,
  gjd_rsp_if.source  rsp_o
);
  import gjd_pkg::*;

  logic [NumStages-1:0] valid_d, valid_q;
  logic [NumStages-1:0] rdy;
  logic [NumStages-1:0] valid_up;

  gjd_req_t    req_data;
  gjd_rsp_t    rsp_data;
  side_t       side_est, side_year;
  logic [13:0] year_est, quot_est;
  yinfo_t      yinfo;
  fix_t        fix;

  // a stage can load when empty or when the next one moves
  always_comb begin
    rdy[NumStages-1] = !valid_q[NumStages-1] || rsp_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
    valid_up = {valid_q[NumStages-2:0], req_i.valid};
    valid_d  = (rdy & valid_up) | (~rdy & valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign req_data    = req_i.data;
  assign req_i.ready = rdy[0];

  gjd_est u_est (
    .clk_i  (clk_i),
    .ld_i   (rdy[1:0]),
    .req_i  (req_data),
    .side_o (side_est),
    .year_o (year_est),
    .quot_o (quot_est)
  );

  gjd_year u_year (
    .clk_i   (clk_i),
    .ld_i    (rdy[3:2]),
    .side_i  (side_est),
    .year_i  (year_est),
    .quot_i  (quot_est),
    .side_o  (side_year),
    .yinfo_o (yinfo)
  );

  gjd_fix u_fix (
    .clk_i   (clk_i),
    .ld_i    (rdy[5:4]),
    .side_i  (side_year),
    .yinfo_i (yinfo),
    .fix_o   (fix)
  );

  gjd_mday u_mday (
    .clk_i (clk_i),
    .ld_i  (rdy[6]),
    .fix_i (fix),
    .rsp_o (rsp_data)
  );

  assign rsp_o.valid = valid_q[NumStages-1];
  assign rsp_o.data  = rsp_data;

endmodule

`default_nettype wire

### design/gjd_est.sv
// ----------------------------------------------------------------------------
// gjd_est: input stage and year estimate
// date field checks, day offset, and the multiply by 1/365.2425
// ----------------------------------------------------------------------------
`default_nettype none

module gjd_est (
  input  logic                  clk_i,
  input  logic [1:0]            ld_i,
  input  gjd_pkg::gjd_req_t     req_i,
  output gjd_pkg::side_t        side_o,
  output logic [13:0]           year_o,
  output logic [13:0]           quot_o
);
  import gjd_pkg::*;

  logic [22:0]         t_full;
  logic [8:0]          mbase;
  logic [8:0]          mlen;
  logic                mok;
  logic                ok0;
  logic                in_range;
  side_t               side_d;
  side_t               side1_q, side2_q;
  logic [13:0]         year1_q, year2_q;
  logic [EstProdW-1:0] prod2_d, prod2_q;

  always_comb begin
    t_full   = req_i.day_number_in - JdnOffset;
    mbase    = days_before(req_i.month_in - 4'd1);
    mlen     = days_before(req_i.month_in) - mbase;
    mok      = req_i.month_in inside {[4'd1:4'd12]};
    ok0      = mok && (req_i.day_in != 5'd0) && ({4'd0, req_i.day_in} <= mlen);
    in_range = (req_i.day_number_in >= JdnOffset) && (req_i.day_number_in <= JdnMax);

    side_d.op    = req_i.op;
    side_d.ok    = (req_i.op == OpToDate) ? in_range : ok0;
    // 29 feb is legal only once the leap flag is known
    side_d.feb29 = (req_i.month_in == 4'd2) && (req_i.day_in == 5'd29);
    side_d.mgt2  = req_i.month_in > 4'd2;
    side_d.doy0  = mbase + {4'd0, req_i.day_in};
    side_d.t     = t_full[TW-1:0];
  end

  assign prod2_d = EstProdW'(side1_q.t) * EstProdW'(EstRecip);

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      side1_q <= side_d;
      year1_q <= req_i.year_in;
    end
    if (ld_i[1]) begin
      side2_q <= side1_q;
      year2_q <= year1_q;
      prod2_q <= prod2_d;
    end
  end

  assign side_o = side2_q;
  assign year_o = year2_q;
  assign quot_o = prod2_q[EstProdW-1:EstShift];

endmodule

`default_nettype wire

### design/gjd_year.sv
// ----------------------------------------------------------------------------
// gjd_year: year unit
// days before a year and leap flags of that year and its two neighbors
// ----------------------------------------------------------------------------
`default_nettype none

module gjd_year (
  input  logic             clk_i,
  input  logic [1:0]       ld_i,
  input  gjd_pkg::side_t   side_i,
  input  logic [13:0]      year_i,
  input  logic [13:0]      quot_i,
  output gjd_pkg::side_t   side_o,
  output gjd_pkg::yinfo_t  yinfo_o
);
  import gjd_pkg::*;

  // p is the year before the working year
  logic [13:0]            p_d, p3_q;
  logic                   yzero_d, yzero3_q;
  logic [Div100ProdW-1:0] prod3_q;
  side_t                  side3_q, side4_q;
  logic [7:0]             q100;
  logic [13:0]            r100_full;
  logic [6:0]             r100;
  logic [23:0]            dby_pos;
  yinfo_t                 yinfo_d, yinfo4_q;

  always_comb begin
    p_d     = (side_i.op == OpToDate) ? quot_i : year_i - 14'd1;
    yzero_d = (side_i.op == OpToJdn) && (year_i == 14'd0);
  end

  always_comb begin
    q100      = prod3_q[Div100ProdW-1:Div100Shift];
    r100_full = p3_q - 14'(q100) * 14'd100;
    r100      = r100_full[6:0];
    dby_pos   = 24'(p3_q) * 24'd365 + 24'(p3_q[13:2]) - 24'(q100) + 24'(q100[7:2]);

    yinfo_d.yw      = p3_q + 14'd1;
    yinfo_d.dby     = yzero3_q ? -24'sd366 : $signed(dby_pos);
    yinfo_d.leap_m1 = ((p3_q[1:0] == 2'd0) && (r100 != 7'd0)) ||
                      ((r100 == 7'd0) && (q100[1:0] == 2'd0));
    yinfo_d.leap0   = yzero3_q ||
                      ((p3_q[1:0] == 2'd3) && (r100 != 7'd99)) ||
                      ((r100 == 7'd99) && (q100[1:0] == 2'd3));
    yinfo_d.leap_p1 = ((p3_q[1:0] == 2'd2) && (r100 != 7'd98)) ||
                      ((r100 == 7'd98) && (q100[1:0] == 2'd3));
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      p3_q     <= p_d;
      yzero3_q <= yzero_d;
      prod3_q  <= Div100ProdW'(p_d) * Div100ProdW'(Recip100);
      side3_q  <= side_i;
    end
    if (ld_i[1]) begin
      yinfo4_q <= yinfo_d;
      side4_q  <= side3_q;
    end
  end

  assign side_o  = side4_q;
  assign yinfo_o = yinfo4_q;

endmodule

`default_nettype wire

### design/gjd_fix.sv
// ----------------------------------------------------------------------------
// gjd_fix: day number sum and year correction
// forms the day number for dates, corrects the year estimate for day numbers
// ----------------------------------------------------------------------------
`default_nettype none

module gjd_fix (
  input  logic             clk_i,
  input  logic [1:0]       ld_i,
  input  gjd_pkg::side_t   side_i,
  input  gjd_pkg::yinfo_t  yinfo_i,
  output gjd_pkg::fix_t    fix_o
);
  import gjd_pkg::*;

  logic               ok5_d;
  logic [8:0]         doy;
  logic signed [23:0] jsum;
  logic signed [23:0] n0_d;

  logic               op5_q, ok5_q;
  logic [22:0]        jdn5_q;
  logic signed [23:0] n05_q;
  logic [13:0]        yw5_q;
  logic               lm1_q, l0_q, lp1_q;

  logic               dec, inc, okr;
  logic signed [23:0] dm1, d0, n2;
  fix_t               fix_d, fix6_q;

  always_comb begin
    ok5_d = side_i.ok || ((side_i.op == OpToJdn) && side_i.feb29 && yinfo_i.leap0);
    doy   = side_i.doy0 + {8'd0, side_i.mgt2 & yinfo_i.leap0};
    jsum  = $signed(yinfo_i.dby) + $signed({15'd0, doy}) + $signed({1'b0, JdnOffset});
    n0_d  = $signed({2'b00, side_i.t}) - $signed(yinfo_i.dby);
  end

  // estimate one too high: n0 <= 0; one too low: n0 beyond the year length
  always_comb begin
    dm1 = 24'sd365 + $signed({23'd0, lm1_q});
    d0  = 24'sd365 + $signed({23'd0, l0_q});
    dec = n05_q[23] || (n05_q == 24'sd0);
    inc = !dec && (n05_q > d0);
    if (dec) begin
      n2 = n05_q + dm1;
    end else if (inc) begin
      n2 = n05_q - d0;
    end else begin
      n2 = n05_q;
    end
    okr = (n2 >= 24'sd1) && (n2 <= 24'sd366);

    fix_d.op  = op5_q;
    fix_d.ok  = ok5_q && ((op5_q == OpToJdn) || okr);
    fix_d.jdn = jdn5_q;
    fix_d.n   = n2[8:0];
    if (dec) begin
      fix_d.yr = yw5_q - 14'd1;
      fix_d.lf = lm1_q;
    end else if (inc) begin
      fix_d.yr = yw5_q + 14'd1;
      fix_d.lf = lp1_q;
    end else begin
      fix_d.yr = yw5_q;
      fix_d.lf = l0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      op5_q  <= side_i.op;
      ok5_q  <= ok5_d;
      jdn5_q <= jsum[22:0];
      n05_q  <= n0_d;
      yw5_q  <= yinfo_i.yw;
      lm1_q  <= yinfo_i.leap_m1;
      l0_q   <= yinfo_i.leap0;
      lp1_q  <= yinfo_i.leap_p1;
    end
    if (ld_i[1]) begin
      fix6_q <= fix_d;
    end
  end

  assign fix_o = fix6_q;

endmodule

`default_nettype wire

### design/gjd_mday.sv
// ----------------------------------------------------------------------------
// gjd_mday: month and day split and output register
// splits the day of year into month and day and zeroes unused fields
// ----------------------------------------------------------------------------
`default_nettype none

module gjd_mday (
  input  logic               clk_i,
  input  logic               ld_i,
  input  gjd_pkg::fix_t      fix_i,
  output gjd_pkg::gjd_rsp_t  rsp_o
);
  import gjd_pkg::*;

  logic     lx;
  logic [3:0] mo;
  logic [8:0] dd;
  logic     found;
  gjd_rsp_t rsp_d, rsp_q;

  always_comb begin
    lx = fix_i.lf && (fix_i.n > 9'd59);
    mo = 4'd0;
    // first month whose end reaches n
    for (int i = 12; i >= 1; i--) begin
      if (fix_i.n <= days_before(4'(i)) + {8'd0, lx}) begin
        mo = 4'(i);
      end
    end
    found = mo != 4'd0;
    dd    = fix_i.n - days_before(mo - 4'd1) - {8'd0, (mo > 4'd2) & lx};

    rsp_d           = '0;
    rsp_d.valid_res = fix_i.ok && ((fix_i.op == OpToJdn) || found);
    if (rsp_d.valid_res) begin
      if (fix_i.op == OpToJdn) begin
        rsp_d.day_number_out = fix_i.jdn;
      end else begin
        rsp_d.year_out  = fix_i.yr;
        rsp_d.month_out = mo;
        rsp_d.day_out   = dd[4:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

`default_nettype wire
